>>> rtl/sensor_frame_dew_point_top_defines.svh
// ----------------------------------------------------------------------------
// sensor frame dew point assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_DEW_POINT_TOP_DEFINES_SVH
`define SENSOR_FRAME_DEW_POINT_TOP_DEFINES_SVH

// same-cycle implication
`define SFDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sfdp_pkg.sv
// ----------------------------------------------------------------------------
// sfdp_pkg
// shared types and constants of the sensor frame dew point block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfdp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int HUM_W         = 12;
  localparam int TEMP_W        = 12;
  localparam int TMAG_W        = 11;
  localparam int DEW_W         = 12;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] SIGN_BIT_MASK = 8'h80;
  localparam logic [7:0] MAG_MASK      = 8'h7f;

  // magnus coefficients in tenths
  localparam int A10_POS = 75;
  localparam int A10_NEG = 76;
  localparam int B10_POS = 2373;
  localparam int B10_NEG = 2407;

  localparam int DEW_LIMIT = 2000;

  localparam logic [63:0] LOG10_2_Q32 = 64'd1292913986;

  typedef struct packed {
    logic                     ok;
    logic                     neg;
    logic                     hum_nz;
    logic [HUM_W-1:0]         hum;
    logic [TMAG_W-1:0]        tmag;
    logic signed [TEMP_W-1:0] temp;
  } frame_t;

endpackage

>>> rtl/sfdp_front.sv
// ----------------------------------------------------------------------------
// sfdp_front
// checksum check and decode of one frame into the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfdp_front (
  input  logic            in_valid_i,
  input  logic            full_i,
  input  logic [7:0]      humidity_int_i,
  input  logic [7:0]      humidity_frac_i,
  input  logic [7:0]      temp_int_i,
  input  logic [7:0]      temp_frac_i,
  input  logic [7:0]      check_byte_i,
  output logic            push_o,
  output logic            stall_o,
  output sfdp_pkg::frame_t frame_o
);
  import sfdp_pkg::*;

  logic [9:0]        sum_w;
  logic              ok_w;
  logic [HUM_W-1:0]  hum_w;
  logic [7:0]        mag8_w;
  logic [TMAG_W-1:0] tmag_w;
  logic              sign_w;
  logic              neg_w;

  assign sum_w  = 10'(humidity_int_i) + 10'(humidity_frac_i) + 10'(temp_int_i)
                + 10'(temp_frac_i);
  assign ok_w   = (sum_w[7:0] == check_byte_i);
  assign hum_w  = HUM_W'(humidity_int_i) * HUM_W'(10) + HUM_W'(humidity_frac_i);
  assign mag8_w = temp_int_i & MAG_MASK;
  assign tmag_w = TMAG_W'(mag8_w) * TMAG_W'(10) + TMAG_W'(temp_frac_i);
  assign sign_w = ((temp_int_i & SIGN_BIT_MASK) != 8'h00);
  assign neg_w  = sign_w && (tmag_w != '0);

  always_comb begin
    frame_o = '0;
    if (ok_w) begin
      frame_o.ok     = 1'b1;
      frame_o.hum    = hum_w;
      frame_o.hum_nz = (hum_w != '0);
      frame_o.neg    = neg_w;
      frame_o.tmag   = tmag_w;
      frame_o.temp   = neg_w ? -$signed({1'b0, tmag_w}) : $signed({1'b0, tmag_w});
    end
  end

  assign stall_o = full_i;
  assign push_o  = in_valid_i && !full_i;

endmodule

>>> rtl/sfdp_queue.sv
// ----------------------------------------------------------------------------
// sfdp_queue
// short queue of decoded frames between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfdp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfdp_pkg::frame_t data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output sfdp_pkg::frame_t head_o
);
  import sfdp_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  frame_t          mem_q [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/sfdp_back.sv
// ----------------------------------------------------------------------------
// sfdp_back
// pipelined log, slope division and dew point division with output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfdp_back #(
  parameter int FRAC_BITS = sfdp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sfdp_pkg::frame_t               head_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           frame_ok_o,
  output logic [sfdp_pkg::HUM_W-1:0]     humidity_tenths_o,
  output logic signed [sfdp_pkg::TEMP_W-1:0] temp_tenths_o,
  output logic signed [sfdp_pkg::DEW_W-1:0]  dew_tenths_o,
  output logic                           dew_valid_o
);
  import sfdp_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int P   = F + 4;
  localparam int MW  = F + 1;
  localparam int LW  = F + 4;
  localparam int DVW = 16;
  localparam int RW  = F + 19;
  localparam int TW  = P + 1;
  localparam int VW  = F + 6;
  localparam int DNW = F + 10;
  localparam int DU  = DNW - 1;
  localparam int NW  = F + 20;
  localparam int RW2 = F + 22;
  localparam int QW  = DEW_W;

  localparam logic [63:0]   L10C_W  = (LOG10_2_Q32 + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic [F-1:0]  L10C    = L10C_W[F-1:0];
  localparam logic [VW-1:0] THREE_Q = VW'(3) << F;

  typedef struct packed {
    logic [MW-1:0]  m;
    logic [LW-1:0]  res;
    logic [RW-1:0]  rem;
    logic [DVW-1:0] dv;
    logic [P-1:0]   q;
  } lstg_t;

  typedef struct packed {
    logic [RW2-1:0] rem;
    logic [DU-1:0]  du;
    logic [QW-1:0]  q;
    logic           ovf;
    logic           nsign;
    logic           dpos;
  } dstg_t;

  logic en;
  logic out_valid_q;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && !empty_i;

  // ---------------- entry stage
  logic [3:0]        e_w;
  logic [F+HUM_W-1:0] mwide_w;
  logic [6:0]        a10_w;
  logic [11:0]       b10_w;
  logic [17:0]       tprod_w;
  logic [11:0]       dsum_w;
  logic [DVW-1:0]    dv_w;
  lstg_t             st0_w;

  always_comb begin
    e_w = '0;
    for (int i = 0; i < HUM_W; i++) begin
      if (head_i.hum[i]) begin
        e_w = 4'(i);
      end
    end
  end

  assign mwide_w = {head_i.hum, {F{1'b0}}} >> e_w;
  assign a10_w   = head_i.neg ? 7'(A10_NEG) : 7'(A10_POS);
  assign b10_w   = head_i.neg ? 12'(B10_NEG) : 12'(B10_POS);
  assign tprod_w = 18'(a10_w) * 18'(head_i.tmag);
  assign dsum_w  = head_i.neg ? b10_w - 12'(head_i.tmag) : b10_w + 12'(head_i.tmag);
  assign dv_w    = DVW'(dsum_w) * DVW'(10);

  always_comb begin
    st0_w.m   = mwide_w[F:0];
    st0_w.res = {e_w, {F{1'b0}}};
    st0_w.rem = (RW'(tprod_w) << F) + RW'(dv_w >> 1);
    st0_w.dv  = dv_w;
    st0_w.q   = '0;
  end

  // ---------------- log2 squaring and slope division
  lstg_t  ls_q [P+1];
  frame_t lf_q [P+1];
  logic [P:0] lv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ls_q[0] <= st0_w;
      lf_q[0] <= head_i;
    end
  end

  for (genvar k = 0; k < P; k++) begin : g_ls
    lstg_t         nxt;
    logic [RW-1:0] dd;
    logic [MW-1:0] m_n;
    logic [LW-1:0] res_n;

    assign dd = RW'(ls_q[k].dv) << (P - 1 - k);

    if (k < F) begin : g_log
      logic [2*MW-1:0] sq;
      logic [F+1:0]    t;
      assign sq = (2*MW)'(ls_q[k].m) * (2*MW)'(ls_q[k].m);
      assign t  = sq[2*F+1:F];
      always_comb begin
        res_n = ls_q[k].res;
        if (t[F+1]) begin
          m_n            = t[F+1:1];
          res_n[F-1-k]   = 1'b1;
        end else begin
          m_n = t[F:0];
        end
      end
    end else begin : g_pass
      assign m_n   = ls_q[k].m;
      assign res_n = ls_q[k].res;
    end

    always_comb begin
      nxt     = ls_q[k];
      nxt.m   = m_n;
      nxt.res = res_n;
      if (ls_q[k].rem >= dd) begin
        nxt.rem          = ls_q[k].rem - dd;
        nxt.q[P-1-k]     = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ls_q[k+1] <= nxt;
        lf_q[k+1] <= lf_q[k];
      end
    end
  end

  // ---------------- log10 scale and signed slope term
  logic [LW+F-1:0]    prod_w, prnd_w;
  logic [TW-1:0]      tq_w;
  logic signed [TW-1:0] term_w;
  logic [LW-1:0]      l10_q;
  logic signed [TW-1:0] term_q;
  frame_t             s1f_q;
  logic               s1v_q;

  assign prod_w = (LW+F)'(ls_q[P].res) * (LW+F)'(L10C);
  assign prnd_w = prod_w + ((LW+F)'(1) << (F - 1));
  assign tq_w   = {1'b0, ls_q[P].q};
  assign term_w = lf_q[P].neg ? -$signed(tq_w) : $signed(tq_w);

  always_ff @(posedge clk_i) begin
    if (en) begin
      l10_q  <= prnd_w[LW+F-1:F];
      term_q <= term_w;
      s1f_q  <= lf_q[P];
    end
  end

  // ---------------- v in q(F)
  logic signed [VW-1:0] v_w, v_q;
  frame_t               s2f_q;
  logic                 s2v_q;

  assign v_w = $signed({2'b00, l10_q}) - $signed(THREE_Q) + VW'(term_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q   <= v_w;
      s2f_q <= s1f_q;
    end
  end

  // ---------------- denominator and numerator magnitude
  logic [6:0]            a10b_w;
  logic signed [DNW-1:0] v10_w, af_w, den_w, den_q;
  logic [VW-1:0]         vabs_w;
  logic [14:0]           b10x_w;
  logic [NW-1:0]         nmag_w, nmag_q;
  logic                  nsign_q;
  frame_t                s3f_q;
  logic                  s3v_q;

  assign a10b_w = s2f_q.neg ? 7'(A10_NEG) : 7'(A10_POS);
  assign b10x_w = s2f_q.neg ? 15'(B10_NEG * 10) : 15'(B10_POS * 10);
  assign v10_w  = (DNW'(v_q) <<< 3) + (DNW'(v_q) <<< 1);
  assign af_w   = $signed(DNW'(a10b_w) << F);
  assign den_w  = af_w - v10_w;
  assign vabs_w = v_q[VW-1] ? VW'(-v_q) : VW'(v_q);
  assign nmag_w = NW'(b10x_w) * NW'(vabs_w[VW-2:0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q   <= den_w;
      nmag_q  <= nmag_w;
      nsign_q <= v_q[VW-1];
      s3f_q   <= s2f_q;
    end
  end

  // ---------------- dew point division
  dstg_t          d0_w;
  logic [DU-1:0]  du_w;
  logic [RW2-1:0] radd_w;
  dstg_t          dq_q [QW+1];
  frame_t         df_q [QW+1];
  logic [QW:0]    dqv_q;

  assign du_w   = den_q[DU-1:0];
  assign radd_w = RW2'(nmag_q) + RW2'(du_w >> 1);

  always_comb begin
    d0_w.rem   = radd_w;
    d0_w.du    = du_w;
    d0_w.q     = '0;
    d0_w.ovf   = (radd_w >= (RW2'(du_w) << QW));
    d0_w.nsign = nsign_q;
    d0_w.dpos  = !den_q[DNW-1] && (den_q != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dq_q[0] <= d0_w;
      df_q[0] <= s3f_q;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_dq
    dstg_t          nxt;
    logic [RW2-1:0] dd;

    assign dd = RW2'(dq_q[k].du) << (QW - 1 - k);

    always_comb begin
      nxt = dq_q[k];
      if (dq_q[k].rem >= dd) begin
        nxt.rem         = dq_q[k].rem - dd;
        nxt.q[QW-1-k]   = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dq_q[k+1] <= nxt;
        df_q[k+1] <= df_q[k];
      end
    end
  end

  // ---------------- saturation and output register
  logic [QW-1:0]        mag_w;
  logic                 dval_w;
  logic signed [QW-1:0] dew_w;

  assign mag_w  = (dq_q[QW].ovf || (dq_q[QW].q > QW'(DEW_LIMIT))) ? QW'(DEW_LIMIT)
                                                                 : dq_q[QW].q;
  assign dval_w = df_q[QW].hum_nz && dq_q[QW].dpos;
  assign dew_w  = !dval_w ? '0 : (dq_q[QW].nsign ? -$signed(mag_w) : $signed(mag_w));

  always_ff @(posedge clk_i) begin
    if (en) begin
      frame_ok_o        <= df_q[QW].ok;
      humidity_tenths_o <= df_q[QW].hum;
      temp_tenths_o     <= df_q[QW].temp;
      dew_tenths_o      <= dew_w;
      dew_valid_o       <= dval_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q        <= '0;
      s1v_q       <= 1'b0;
      s2v_q       <= 1'b0;
      s3v_q       <= 1'b0;
      dqv_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      lv_q        <= {lv_q[P-1:0], !empty_i};
      s1v_q       <= lv_q[P];
      s2v_q       <= s1v_q;
      s3v_q       <= s2v_q;
      dqv_q       <= {dqv_q[QW-1:0], s3v_q};
      out_valid_q <= dqv_q[QW];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/sensor_frame_dew_point_top.sv
// ----------------------------------------------------------------------------
// sensor_frame_dew_point_top
// Humidity/temperature frame decoder with magnus dew point.
// Input channel: in_valid_i / in_stall_o with the five frame bytes; a
// transfer happens on a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with the decoded fields and the
// dew point; one result per input transfer, in order.
// The front checks the checksum and decodes the frame into a two-entry
// queue; the back pipeline takes one frame a cycle from that queue while
// out_stall_i holds no result; throughput is then one frame per cycle.
// From the input transfer to out_valid_o a frame passes the queue, the
// FRAC_BITS log squaring stages, the slope and dew point division stages.
// When out_stall_i holds a waiting result, the whole back pipeline holds,
// the queue fills and in_stall_o rises two frames later.
// Reset clears all valid flags and queue pointers; no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_frame_dew_point_top #(
  parameter int FRAC_BITS = sfdp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         humidity_int_i,
  input  logic [7:0]                         humidity_frac_i,
  input  logic [7:0]                         temp_int_i,
  input  logic [7:0]                         temp_frac_i,
  input  logic [7:0]                         check_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               frame_ok_o,
  output logic [sfdp_pkg::HUM_W-1:0]         humidity_tenths_o,
  output logic signed [sfdp_pkg::TEMP_W-1:0] temp_tenths_o,
  output logic signed [sfdp_pkg::DEW_W-1:0]  dew_tenths_o,
  output logic                               dew_valid_o
);
  import sfdp_pkg::*;

  frame_t cls_w;
  frame_t head_w;
  logic   push_w, full_w, empty_w, pop_w;

  sfdp_front u_front (
    .in_valid_i      (in_valid_i),
    .full_i          (full_w),
    .humidity_int_i  (humidity_int_i),
    .humidity_frac_i (humidity_frac_i),
    .temp_int_i      (temp_int_i),
    .temp_frac_i     (temp_frac_i),
    .check_byte_i    (check_byte_i),
    .push_o          (push_w),
    .stall_o         (in_stall_o),
    .frame_o         (cls_w)
  );

  sfdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .data_i  (cls_w),
    .pop_i   (pop_w),
    .full_o  (full_w),
    .empty_o (empty_w),
    .head_o  (head_w)
  );

  sfdp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head_w),
    .empty_i           (empty_w),
    .pop_o             (pop_w),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .frame_ok_o        (frame_ok_o),
    .humidity_tenths_o (humidity_tenths_o),
    .temp_tenths_o     (temp_tenths_o),
    .dew_tenths_o      (dew_tenths_o),
    .dew_valid_o       (dew_valid_o)
  );

endmodule

>>> rtl/sfdp_checker.sv
// ----------------------------------------------------------------------------
// sfdp_checker
// port level checks of the dew point block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sensor_frame_dew_point_top_defines.svh"

module sfdp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [7:0]         humidity_int_i,
  input logic [7:0]         humidity_frac_i,
  input logic [7:0]         temp_int_i,
  input logic [7:0]         temp_frac_i,
  input logic [7:0]         check_byte_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               frame_ok_o,
  input logic [11:0]        humidity_tenths_o,
  input logic signed [11:0] temp_tenths_o,
  input logic signed [11:0] dew_tenths_o,
  input logic               dew_valid_o
);

  `SFDP_ASSERT_NOW(a_bad_frame_zero, out_valid_o && !frame_ok_o, humidity_tenths_o == 12'd0 && temp_tenths_o == 12'sd0 && dew_tenths_o == 12'sd0 && !dew_valid_o, "bad frame with nonzero fields")
  `SFDP_ASSERT_NOW(a_invalid_dew_zero, out_valid_o && !dew_valid_o, dew_tenths_o == 12'sd0, "invalid dew point not zero")
  `SFDP_ASSERT_NOW(a_dew_range, out_valid_o, dew_tenths_o <= 12'sd2000 && dew_tenths_o >= -12'sd2000, "dew point out of range")
  `SFDP_ASSERT_NOW(a_dry_invalid, out_valid_o && humidity_tenths_o == 12'd0, !dew_valid_o, "dew valid at zero humidity")
  `SFDP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(dew_tenths_o) && $stable(humidity_tenths_o), "stalled result changed")

endmodule

bind sensor_frame_dew_point_top sfdp_checker u_sfdp_checker (.*);
